>>> hdl/gsbr_pkg.sv
// Shared constants and types of the gyro static bias removal block.
// Used by the divider, the axis lanes and the top level; depends on nothing.
package gsbr_pkg;

  // Number of gyro axes, one lane each.
  localparam int AXES = 3;

  // Fixed widths of the rate fields, the alignment register and the sums.
  localparam int FIELD_BITS = 32;
  localparam int ALIGN_BITS = 24;
  localparam int SUM_BITS   = 64;

  // Alignment length after reset, in navigation steps.
  localparam logic [ALIGN_BITS-1:0] ALIGN_RESET = 24'd30000;

  // Defaults of the top-level parameters.
  localparam int COUNT_BITS_DEF = 24;
  localparam int RATE_BITS_DEF  = 32;

  // Control that the sequencer hands to every axis lane.
  typedef struct packed {
    logic accumulate;  // add this request's rate to the running sum
    logic div_start;   // start the mean division
    logic correct;     // subtract the mean from the held rate
  } lane_ctrl_t;

endpackage

>>> hdl/gsbr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Unsigned dividend and divisor; uses gsbr_pkg for the default widths only.
module gsbr_div
  import gsbr_pkg::*;
#(
  parameter int DIVIDEND_BITS = SUM_BITS,
  parameter int DIVISOR_BITS  = COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DIVIDEND_BITS-1:0] dividend_i,
  input  logic [DIVISOR_BITS-1:0]  divisor_i,
  output logic                     done_o,
  output logic [DIVIDEND_BITS-1:0] quotient_o
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [CNT_BITS-1:0]      cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic [DIVIDEND_BITS-1:0] quo_q, quo_d;
  logic [DIVISOR_BITS:0]    rem_q, rem_d;
  logic [DIVISOR_BITS-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_BITS:0]    rem_shift;
  logic                     fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_shift = {rem_q[DIVISOR_BITS-1:0], quo_q[DIVIDEND_BITS-1]};
    fits      = rem_shift >= {1'b0, dvs_q};
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    if (start_i) begin
      cnt_d = CNT_BITS'(DIVIDEND_BITS);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_BITS'(1));
      quo_d  = {quo_q[DIVIDEND_BITS-2:0], fits};
      rem_d  = fits ? (rem_shift - {1'b0, dvs_q}) : rem_shift;
    end
  end

  // Control state is reset; the data path is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hdl/gsbr_lane.sv
// One axis lane: saturating rate sum, bias mean by iterative division,
// and saturated bias correction. Depends on gsbr_pkg and gsbr_div.
module gsbr_lane
  import gsbr_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int RATE_BITS  = RATE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lane_ctrl_t                   ctrl_i,
  input  logic signed [FIELD_BITS-1:0] rate_i,
  input  logic [COUNT_BITS-1:0]        sample_count_i,
  output logic                         done_o,
  output logic [FIELD_BITS-1:0]        result_o
);

  // Saturation range of the corrected rate and of the mean.
  localparam int SAT_BITS = (RATE_BITS > FIELD_BITS) ? FIELD_BITS : RATE_BITS;
  localparam logic signed [SUM_BITS:0] RATE_HI =
      (65'sd1 <<< (SAT_BITS - 1)) - 65'sd1;
  localparam logic signed [SUM_BITS:0] RATE_LO = -RATE_HI - 65'sd1;

  function automatic logic signed [SUM_BITS:0] clamp_rate(
      input logic signed [SUM_BITS:0] v);
    logic signed [SUM_BITS:0] r;
    r = v;
    if (v > RATE_HI) r = RATE_HI;
    if (v < RATE_LO) r = RATE_LO;
    return r;
  endfunction

  logic signed [SUM_BITS-1:0]   sum_q, sum_d;
  logic signed [SUM_BITS-1:0]   sum_add;
  logic signed [FIELD_BITS-1:0] mean_q, mean_d;
  logic                         neg_q;
  logic [SUM_BITS-1:0]          sum_mag;
  logic [SUM_BITS-1:0]          quo;
  logic                         div_done;
  logic signed [SUM_BITS:0]     quo_signed;
  logic signed [SUM_BITS:0]     diff;

  // Running sum that sticks at the signed 64-bit limits.
  always_comb begin
    sum_add = sum_q + SUM_BITS'(rate_i);
    sum_d   = sum_q;
    if (ctrl_i.accumulate) begin
      if ((sum_q[SUM_BITS-1] == rate_i[FIELD_BITS-1]) &&
          (sum_add[SUM_BITS-1] != sum_q[SUM_BITS-1])) begin
        sum_d = rate_i[FIELD_BITS-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                     : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
        sum_d = sum_add;
      end
    end
  end

  // The divider works on magnitudes; the sign is restored afterwards.
  assign sum_mag = sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);

  gsbr_div #(
    .DIVIDEND_BITS(SUM_BITS),
    .DIVISOR_BITS (COUNT_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctrl_i.div_start),
    .dividend_i(sum_mag),
    .divisor_i (sample_count_i),
    .done_o    (div_done),
    .quotient_o(quo)
  );

  // Truncated mean, clamped to the rate range; zero when nothing was counted.
  always_comb begin
    quo_signed = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    mean_d     = mean_q;
    if (div_done) begin
      if (sample_count_i == '0) begin
        mean_d = '0;
      end else begin
        mean_d = FIELD_BITS'(clamp_rate(quo_signed));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      mean_q <= '0;
      neg_q  <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      mean_q <= mean_d;
      if (ctrl_i.div_start) begin
        neg_q <= sum_q[SUM_BITS-1];
      end
    end
  end

  // Corrected rate, or the input unchanged when no correction applies.
  assign diff     = (SUM_BITS + 1)'(rate_i) - (SUM_BITS + 1)'(mean_q);
  assign result_o = ctrl_i.correct ? FIELD_BITS'(clamp_rate(diff)) : rate_i;
  assign done_o   = div_done;

endmodule

>>> hdl/gyro_static_bias_removal.sv
// Gyro static bias removal, top level: step sequencer, three axis lanes
// and the merging output register. Depends on gsbr_pkg and gsbr_lane.
//
// One request is one navigation step: three Q7.24 gyro rates and a sample
// valid flag. For the first alignment_steps - 1 steps the block sums the
// valid samples per axis and passes the rates through with aligning set.
// On the first step after that it divides each sum by the sample count and
// subtracts this mean from that and every later valid sample, saturated to
// the rate range. A request normally passes through the states accept, update
// and load output before the next request can be accepted. The first
// compensating step also runs the per-lane 64-bit restoring divider, one
// quotient bit a cycle, between update and load output. A result that waits
// in the output register does not block the next request. The alignment
// register may be written at any time the block is idle; no clearing pass
// is needed after reset.
module gyro_static_bias_removal
  import gsbr_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int RATE_BITS  = RATE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [ALIGN_BITS-1:0] cfg_data_i,
  // Input channel.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FIELD_BITS-1:0] rate_x_i,
  input  logic [FIELD_BITS-1:0] rate_y_i,
  input  logic [FIELD_BITS-1:0] rate_z_i,
  input  logic                  sample_valid_i,
  // Result channel.
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [FIELD_BITS-1:0] out_rate_x_o,
  output logic [FIELD_BITS-1:0] out_rate_y_o,
  output logic [FIELD_BITS-1:0] out_rate_z_o,
  output logic                  out_valid_o,
  output logic                  aligning_o
);

  localparam int CMP_BITS = ((COUNT_BITS > ALIGN_BITS) ? COUNT_BITS : ALIGN_BITS) + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [ALIGN_BITS-1:0]        align_q;
  logic [COUNT_BITS-1:0]        step_q;
  logic [COUNT_BITS-1:0]        sample_count_q;
  logic                         mean_ready_q;
  logic                         align_flag_q;
  logic                         valid_q;
  logic signed [FIELD_BITS-1:0] rate_q [AXES];
  logic [FIELD_BITS-1:0]        rate_in [AXES];
  logic [FIELD_BITS-1:0]        lane_res [AXES];
  logic [AXES-1:0]              lane_done;
  lane_ctrl_t                   lane_ctrl;
  logic [CMP_BITS-1:0]          next_step;
  logic                         aligning_c;
  logic                         all_done;
  logic                         out_load;
  logic                         res_valid_q;
  logic [FIELD_BITS-1:0]        res_rate_q [AXES];
  logic                         res_sv_q;
  logic                         res_align_q;

  assign rate_in[0] = rate_x_i;
  assign rate_in[1] = rate_y_i;
  assign rate_in[2] = rate_z_i;

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  // Next step count: saturate at the counter limit and at the alignment length.
  always_comb begin
    next_step = CMP_BITS'(step_q) + CMP_BITS'(1);
    if (next_step > CMP_BITS'(COUNT_MAX)) next_step = CMP_BITS'(COUNT_MAX);
    if (next_step > CMP_BITS'(align_q))   next_step = CMP_BITS'(align_q);
    aligning_c = next_step < CMP_BITS'(align_q);
  end

  // Merging: all lanes run the same divide, so they finish together.
  assign all_done = &lane_done;
  assign out_load = (state_q == ST_OUT) && (!res_valid_q || res_ready_i);

  // Step sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (!aligning_c && !mean_ready_q) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (all_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Lane control for the current step.
  always_comb begin
    lane_ctrl.accumulate = (state_q == ST_CALC) && aligning_c && valid_q;
    lane_ctrl.div_start  = (state_q == ST_CALC) && !aligning_c && !mean_ready_q;
    lane_ctrl.correct    = valid_q && !align_flag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      align_q        <= ALIGN_RESET;
      step_q         <= '0;
      sample_count_q <= '0;
      mean_ready_q   <= 1'b0;
      align_flag_q   <= 1'b0;
      valid_q        <= 1'b0;
      res_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        align_q <= cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        valid_q <= sample_valid_i;
      end
      if (state_q == ST_CALC) begin
        step_q       <= next_step[COUNT_BITS-1:0];
        align_flag_q <= aligning_c;
        if (aligning_c) begin
          mean_ready_q <= 1'b0;
          if (valid_q && (sample_count_q != COUNT_MAX)) begin
            sample_count_q <= sample_count_q + 1'b1;
          end
        end
      end
      if ((state_q == ST_DIV) && all_done) begin
        mean_ready_q <= 1'b1;
      end
      if (out_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers of the held request and of the output stage.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      for (int k = 0; k < AXES; k++) begin
        rate_q[k] <= rate_in[k];
      end
    end
    if (out_load) begin
      for (int k = 0; k < AXES; k++) begin
        res_rate_q[k] <= lane_res[k];
      end
      res_sv_q    <= valid_q;
      res_align_q <= align_flag_q;
    end
  end

  // One lane per axis.
  for (genvar g = 0; g < AXES; g++) begin : g_lane
    gsbr_lane #(
      .COUNT_BITS(COUNT_BITS),
      .RATE_BITS (RATE_BITS)
    ) u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (lane_ctrl),
      .rate_i        (rate_q[g]),
      .sample_count_i(sample_count_q),
      .done_o        (lane_done[g]),
      .result_o      (lane_res[g])
    );
  end

  assign res_valid_o  = res_valid_q;
  assign out_rate_x_o = res_rate_q[0];
  assign out_rate_y_o = res_rate_q[1];
  assign out_rate_z_o = res_rate_q[2];
  assign out_valid_o  = res_sv_q;
  assign aligning_o   = res_align_q;

  // The lanes finish their divisions in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (lane_done == '0) || (lane_done == '1))
    else $error("axis lanes finished the mean division out of step");

  // A division starts only when no valid mean is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      lane_ctrl.div_start |-> !mean_ready_q)
    else $error("mean division started while a mean was ready");

  // A compensating result is only loaded with a computed mean.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_load && !align_flag_q) |-> mean_ready_q)
    else $error("compensated result loaded without a mean");

  // A blocked output register keeps the sequencer waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((state_q == ST_OUT) && res_valid_q && !res_ready_i) |=> (state_q == ST_OUT))
    else $error("sequencer left the output state while the result was blocked");

endmodule

>>> tb/gyro_static_bias_removal_tb.sv
// Self-checking testbench for the gyro static bias removal block: directed table, then
// random gyro steps under several alignment lengths and idling mixes. Depends on gsbr_pkg.
`timescale 1ns / 1ps

module gyro_static_bias_removal_tb;
  import gsbr_pkg::*;

  // One result as seen on the output channel; rate index 0 is the x axis.
  typedef struct packed {
    logic [AXES-1:0][FIELD_BITS-1:0] rate;
    logic                            out_valid;
    logic                            aligning;
  } gyro_res_t;

  // Directed rows are either an alignment write or one gyro step.
  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [ALIGN_BITS-1:0] align;
    logic [FIELD_BITS-1:0] x;
    logic [FIELD_BITS-1:0] y;
    logic [FIELD_BITS-1:0] z;
    logic                  vld;
    logic                  typed;      // pass-through expected, aligning flag below
    logic                  exp_align;
  } dir_row_t;

  localparam longint SUM_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN     = -SUM_MAX - 64'sd1;
  localparam longint RATE_HI     = 64'sd2147483647;
  localparam longint RATE_LO     = -64'sd2147483648;
  localparam longint COUNT_TOP   = (64'sd1 << COUNT_BITS_DEF) - 64'sd1;
  localparam int     QUIET_LIMIT = 4000;
  localparam int     SEGMENTS    = 24;
  localparam int     DIR_ROWS    = 23;

  // Directed steps. Typed rows pass the rates through unchanged; the rest are predicted.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // Reset length, invalid sample: aligning, nothing counted.
    '{ROW_SAMPLE, 24'd0, 32'h12345678, 32'hEDCBA988, 32'hFFFFFFFF, 1'b0, 1'b1, 1'b1},
    // Zero length with no sample counted: compensates at once with a zero mean.
    '{ROW_CFG,    24'd0, 32'h0,        32'h0,        32'h0,        1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, 24'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 1'b1, 1'b1, 1'b0},
    '{ROW_SAMPLE, 24'd0, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 1'b0, 1'b1, 1'b0},
    // Lengthened after compensating: three aligning steps, then a fresh mean.
    '{ROW_CFG,    24'd4, 32'h0,        32'h0,        32'h0,        1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, 24'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 1'b1, 1'b1, 1'b1},
    '{ROW_SAMPLE, 24'd0, 32'h00000001, 32'hFFFFFFFF, 32'h00000064, 1'b1, 1'b1, 1'b1},
    '{ROW_SAMPLE, 24'd0, 32'hAAAAAAAA, 32'h55555555, 32'h0F0F0F0F, 1'b0, 1'b1, 1'b1},
    // Mean taken on this step; x and y saturate at the rate range.
    '{ROW_SAMPLE, 24'd0, 32'h80000000, 32'h7FFFFFFF, 32'h00000000, 1'b1, 1'b0, 1'b0},
    '{ROW_SAMPLE, 24'd0, 32'hAAAAAAAA, 32'h55555555, 32'h0F0F0F0F, 1'b0, 1'b1, 1'b0},
    '{ROW_SAMPLE, 24'd0, 32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF, 1'b1, 1'b0, 1'b0},
    // Realign with the sums kept.
    '{ROW_CFG,    24'd8, 32'h0,        32'h0,        32'h0,        1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, 24'd0, 32'h00001000, 32'hFFFFF000, 32'h00000010, 1'b1, 1'b1, 1'b1},
    '{ROW_SAMPLE, 24'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b1, 1'b1},
    '{ROW_SAMPLE, 24'd0, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b1, 1'b1},
    '{ROW_SAMPLE, 24'd0, 32'h01000000, 32'hFF000000, 32'h00ABCDEF, 1'b1, 1'b0, 1'b0},
    // Shortened mid-run: the step counter is clipped, the mean is kept.
    '{ROW_CFG,    24'd2, 32'h0,        32'h0,        32'h0,        1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, 24'd0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b0},
    // Longest length: aligning for the rest of this stretch.
    '{ROW_CFG, 24'hFFFFFF, 32'h0,      32'h0,        32'h0,        1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, 24'd0, 32'h55555555, 32'hAAAAAAAA, 32'hF0F0F0F0, 1'b1, 1'b1, 1'b1},
    '{ROW_SAMPLE, 24'd0, 32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 1'b1, 1'b1},
    // Shortest nonzero length: compensates again with a recomputed mean.
    '{ROW_CFG,    24'd1, 32'h0,        32'h0,        32'h0,        1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, 24'd0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0, 1'b0}
  };

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [ALIGN_BITS-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [FIELD_BITS-1:0] rate_x_i       = '0;
  logic [FIELD_BITS-1:0] rate_y_i       = '0;
  logic [FIELD_BITS-1:0] rate_z_i       = '0;
  logic                  sample_valid_i = 1'b0;
  logic                  res_valid_o;
  logic                  res_ready_i    = 1'b0;
  logic [FIELD_BITS-1:0] out_rate_x_o;
  logic [FIELD_BITS-1:0] out_rate_y_o;
  logic [FIELD_BITS-1:0] out_rate_z_o;
  logic                  out_valid_o;
  logic                  aligning_o;

  // Bias estimator state kept alongside the block.
  longint align_len = longint'(ALIGN_RESET);
  longint steps_seen;
  longint samples_summed;
  longint axis_sum [AXES];
  longint axis_bias [AXES];
  logic   bias_taken;

  gyro_res_t corrected_q[$];
  int        in_idle_pct   = 0;
  int        out_stall_pct = 0;
  int        next_gap      = 0;
  int        quiet_cycles  = 0;
  int        mismatch_count = 0;
  int        steps_sent    = 0;
  int        results_seen  = 0;
  int        cfg_writes    = 0;

  gyro_static_bias_removal uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rate_x_i       (rate_x_i),
    .rate_y_i       (rate_y_i),
    .rate_z_i       (rate_z_i),
    .sample_valid_i (sample_valid_i),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .out_rate_x_o   (out_rate_x_o),
    .out_rate_y_o   (out_rate_y_o),
    .out_rate_z_o   (out_rate_z_o),
    .out_valid_o    (out_valid_o),
    .aligning_o     (aligning_o)
  );

  // 100 MHz clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Saturating add of one rate into a 64-bit running sum.
  function automatic longint sum_sat(longint s, longint v);
    if (v > 0 && s > SUM_MAX - v) return SUM_MAX;
    if (v < 0 && s < SUM_MIN - v) return SUM_MIN;
    return s + v;
  endfunction

  function automatic longint clamp_rate(longint v);
    if (v > RATE_HI) return RATE_HI;
    if (v < RATE_LO) return RATE_LO;
    return v;
  endfunction

  // Advances the step counter and returns the bias-corrected step.
  function automatic gyro_res_t correct_step(logic [AXES-1:0][FIELD_BITS-1:0] rate, logic vld);
    gyro_res_t res;
    longint    r;
    longint    nxt;
    int        k;
    nxt = steps_seen + 1;
    if (nxt > COUNT_TOP) nxt = COUNT_TOP;
    if (nxt > align_len) nxt = align_len;
    steps_seen    = nxt;
    res.aligning  = (steps_seen < align_len);
    res.out_valid = vld;
    if (res.aligning) begin
      bias_taken = 1'b0;
      if (vld && samples_summed < COUNT_TOP) samples_summed++;
      for (k = 0; k < AXES; k++) begin
        if (vld) axis_sum[k] = sum_sat(axis_sum[k], longint'($signed(rate[k])));
        res.rate[k] = rate[k];
      end
    end else begin
      // The mean is taken once, on the first compensating step.
      if (!bias_taken) begin
        for (k = 0; k < AXES; k++) begin
          if (samples_summed == 0) axis_bias[k] = 0;
          else axis_bias[k] = clamp_rate(axis_sum[k] / samples_summed);
        end
        bias_taken = 1'b1;
      end
      for (k = 0; k < AXES; k++) begin
        r = longint'($signed(rate[k]));
        if (vld) r = clamp_rate(r - axis_bias[k]);
        res.rate[k] = r[FIELD_BITS-1:0];
      end
    end
    return res;
  endfunction

  // Random rate: mostly the stretch's bias plus noise, some full-range and extremes.
  function automatic logic [FIELD_BITS-1:0] pick_rate(logic [FIELD_BITS-1:0] base);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) return 32'h7FFFFFFF;
    if (sel < 16) return 32'h80000000;
    if (sel < 40) return $urandom;
    return base + 32'($urandom_range(4095)) - 32'd2048;
  endfunction

  // Sends one gyro step and records its expected result at acceptance.
  task automatic send_step(input logic [AXES-1:0][FIELD_BITS-1:0] rate, input logic vld,
                           input logic typed, input logic exp_align, input logic last);
    gyro_res_t want;
    repeat (next_gap) @(posedge clk_i);
    in_valid_i     <= 1'b1;
    rate_x_i       <= rate[0];
    rate_y_i       <= rate[1];
    rate_z_i       <= rate[2];
    sample_valid_i <= vld;
    do @(posedge clk_i); while (!in_ready_o);
    want = correct_step(rate, vld);
    if (typed) begin
      want.rate      = rate;
      want.out_valid = vld;
      want.aligning  = exp_align;
    end
    corrected_q.push_back(want);
    steps_sent++;
    // Valid stays high only when the next step follows without a gap.
    next_gap = 0;
    if (!last) begin
      while ($urandom_range(99) < in_idle_pct) next_gap++;
    end
    if (last || next_gap != 0) in_valid_i <= 1'b0;
  endtask

  // Writes the alignment length once every pending result has come back.
  task automatic write_align(input logic [ALIGN_BITS-1:0] len);
    while (corrected_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    align_len = longint'(len);
    cfg_writes++;
  endtask

  // Result side: random stalls and comparison against the oldest expectation.
  always @(posedge clk_i) begin
    gyro_res_t want;
    gyro_res_t got;
    got.rate[0]   = out_rate_x_o;
    got.rate[1]   = out_rate_y_o;
    got.rate[2]   = out_rate_z_o;
    got.out_valid = out_valid_o;
    got.aligning  = aligning_o;
    if (rst_ni && res_valid_o && res_ready_i) begin
      results_seen++;
      if (corrected_q.size() == 0) begin
        $display("%0t: unexpected result rates %h %h %h valid %b aligning %b", $time,
                 got.rate[0], got.rate[1], got.rate[2], got.out_valid, got.aligning);
        mismatch_count++;
      end else begin
        want = corrected_q.pop_front();
        for (int k = 0; k < AXES; k++) begin
          if (got.rate[k] !== want.rate[k]) begin
            $display("%0t: axis %0d rate expected %h, actual %h", $time, k,
                     want.rate[k], got.rate[k]);
            mismatch_count++;
          end
        end
        if (got.out_valid !== want.out_valid) begin
          $display("%0t: out_valid expected %b, actual %b", $time, want.out_valid,
                   got.out_valid);
          mismatch_count++;
        end
        if (got.aligning !== want.aligning) begin
          $display("%0t: aligning expected %b, actual %b", $time, want.aligning,
                   got.aligning);
          mismatch_count++;
        end
      end
    end
    res_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // Counts cycles in which no request moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (res_valid_o && res_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: timeout, no request accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Stimulus: directed table, then random stretches, each with its own length and idling.
  initial begin
    dir_row_t                        row;
    logic                            last;
    logic [AXES-1:0][FIELD_BITS-1:0] base;
    logic [AXES-1:0][FIELD_BITS-1:0] rate;
    logic [ALIGN_BITS-1:0]           len;
    int                              count;
    steps_seen     = 0;
    samples_summed = 0;
    bias_taken     = 1'b0;
    for (int k = 0; k < AXES; k++) begin
      axis_sum[k]  = 0;
      axis_bias[k] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      if (row.kind == ROW_CFG) begin
        write_align(row.align);
      end else begin
        last = 1'b1;
        if (i + 1 < DIR_ROWS) last = (DIR_TABLE[i+1].kind == ROW_CFG);
        send_step({row.z, row.y, row.x}, row.vld, row.typed, row.exp_align, last);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 8)
        1:       len = ALIGN_BITS'($urandom_range(100, 24'hFFFFFF));
        3:       len = '1;
        5:       len = '0;
        7:       len = 24'd1;
        default: len = ALIGN_BITS'($urandom_range(2, 60));
      endcase
      write_align(len);
      case (seg % 4)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 46; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 46; end
        default: begin in_idle_pct = 13; out_stall_pct = 13; end
      endcase
      for (int k = 0; k < AXES; k++) base[k] = $signed($urandom) >>> $urandom_range(0, 28);
      count = $urandom_range(60, 100);
      for (int n = 0; n < count; n++) begin
        for (int k = 0; k < AXES; k++) rate[k] = pick_rate(base[k]);
        send_step(rate, ($urandom_range(99) < 75), 1'b0, 1'b0, (n == count - 1));
      end
    end

    while (corrected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("Sent %0d gyro steps (%0d directed rows) and checked %0d results.",
             steps_sent, DIR_ROWS, results_seen);
    $display("Wrote %0d alignment lengths from zero to the counter maximum.", cfg_writes);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
